// ===== rtl/core/rle_sprite_row_decoder_assert.svh =====
// Assertion macros for the RLE sprite row decoder checker.
// Included by the checker file; depends on nothing else.
`ifndef RLE_SPRITE_ROW_DECODER_ASSERT_SVH
`define RLE_SPRITE_ROW_DECODER_ASSERT_SVH

// Clocked assertion, disabled while reset is asserted
`define RSRD_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("rsrd assertion failed");

// Clocked assertion that also holds during reset
`define RSRD_ASSERT_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("rsrd assertion failed");

`endif

// ===== rtl/core/rsrd_pkg.sv =====
// Shared types, codes, widths and color helpers for the RLE sprite row decoder.
// No dependencies; imported by every module of the block.
package rsrd_pkg;

    // Default sizing
    localparam int MAX_WIDTH_DEF       = 1024;
    localparam int PALETTE_ENTRIES_DEF = 256;

    // Field widths
    localparam int KIND_W      = 2;
    localparam int INDEX_W     = 8;
    localparam int COLOR_W     = 24;
    localparam int ROW_W       = 10;
    localparam int BYTE_W      = 8;
    localparam int TEXEL_X_W   = 10;
    localparam int TEXEL_Y_W   = 10;
    localparam int ARGB_W      = 16;
    localparam int RGB565_W    = 16;
    localparam int SPR_WIDTH_W = 11;

    // Stream widths (tdata padded to whole bytes)
    localparam int IN_FIELDS_W  = INDEX_W + COLOR_W + ROW_W + BYTE_W;
    localparam int IN_TDATA_W   = ((IN_FIELDS_W + 7) / 8) * 8;
    localparam int OUT_FIELDS_W = TEXEL_X_W + TEXEL_Y_W + ARGB_W;
    localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;

    // Configuration port
    localparam int CFG_INDEX_W = 1;
    localparam int CFG_DATA_W  = SPR_WIDTH_W;
    localparam logic [CFG_INDEX_W-1:0] REG_SPRITE_WIDTH   = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_PALETTE_FORMAT = 1'd1;

    // Item kinds
    localparam logic [KIND_W-1:0] KIND_PALETTE = 2'd0;
    localparam logic [KIND_W-1:0] KIND_ROW     = 2'd1;
    localparam logic [KIND_W-1:0] KIND_STREAM  = 2'd2;

    // Palette formats
    localparam logic FMT_RGB565 = 1'b0;
    localparam logic FMT_RGB888 = 1'b1;

    // Row terminator in skip position
    localparam logic [BYTE_W-1:0] END_OF_ROW = 8'hFF;

    localparam logic [3:0] ALPHA_OPAQUE = 4'hF;

    typedef enum logic [1:0] {
        PH_SKIP   = 2'd0,
        PH_COUNT  = 2'd1,
        PH_PIXELS = 2'd2
    } phase_t;

    // Palette write request
    typedef struct packed {
        logic                  we;
        logic [INDEX_W-1:0]    index;
        logic [RGB565_W-1:0]   color;
    } pal_wr_t;

    // Pixel lookup request
    typedef struct packed {
        logic                  emit;
        logic                  hit;    // index lies inside the palette
        logic [TEXEL_X_W-1:0]  x;
        logic [TEXEL_Y_W-1:0]  y;
        logic [INDEX_W-1:0]    index;
    } pix_req_t;

    // RGB888 reduced to RGB565
    function automatic logic [RGB565_W-1:0] rgb888_to_565(input logic [COLOR_W-1:0] c);
        rgb888_to_565 = {c[23:19], c[15:10], c[7:3]};
    endfunction

    // RGB565 to opaque ARGB4444
    function automatic logic [ARGB_W-1:0] rgb565_to_argb(input logic [RGB565_W-1:0] p);
        rgb565_to_argb = {ALPHA_OPAQUE, p[15:12], p[10:7], p[4:1]};
    endfunction

endpackage

// ===== rtl/core/rsrd_palette_ram.sv =====
// Palette memory: one write port, one read port with registered read data.
// Depends on rsrd_pkg for the entry width.
module rsrd_palette_ram #(
    parameter int ENTRIES = rsrd_pkg::PALETTE_ENTRIES_DEF,
    parameter int AW      = (ENTRIES > 1) ? $clog2(ENTRIES) : 1
) (
    input  logic                          aclk,
    input  logic                          wr_en,
    input  logic [AW-1:0]                 wr_addr,
    input  logic [rsrd_pkg::RGB565_W-1:0] wr_data,
    input  logic                          rd_en,
    input  logic [AW-1:0]                 rd_addr,
    output logic [rsrd_pkg::RGB565_W-1:0] rd_data
);
    import rsrd_pkg::*;

    logic [RGB565_W-1:0] mem [ENTRIES];
    logic [RGB565_W-1:0] rd_data_reg;

    // Write port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Read port, data held until the next read
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== rtl/core/rsrd_parser.sv =====
// Run-length row parser: tracks phase, column, run and row per accepted item,
// and issues palette writes and pixel lookups. Depends on rsrd_pkg.
module rsrd_parser #(
    parameter int MAX_WIDTH       = rsrd_pkg::MAX_WIDTH_DEF,
    parameter int PALETTE_ENTRIES = rsrd_pkg::PALETTE_ENTRIES_DEF
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             accept,
    input  logic [rsrd_pkg::KIND_W-1:0]      kind,
    input  logic [rsrd_pkg::INDEX_W-1:0]     palette_index,
    input  logic [rsrd_pkg::COLOR_W-1:0]     palette_color,
    input  logic [rsrd_pkg::ROW_W-1:0]       row_number,
    input  logic [rsrd_pkg::BYTE_W-1:0]      stream_byte,
    input  logic [rsrd_pkg::SPR_WIDTH_W-1:0] sprite_width,
    input  logic                             palette_format,
    output rsrd_pkg::pal_wr_t                pal_wr,
    output rsrd_pkg::pix_req_t               pix_req
);
    import rsrd_pkg::*;

    localparam int CW = $clog2(MAX_WIDTH + 1);
    // Wide enough for column + 255 and for the 11-bit width register
    localparam int XW = CW + 9;
    localparam logic [XW-1:0] MAX_W_X = XW'(MAX_WIDTH);

    phase_t          phase_reg,  phase_next;
    logic [CW-1:0]   column_reg, column_next;
    logic [7:0]      run_reg,    run_next;
    logic [ROW_W-1:0] row_reg,   row_next;
    logic            active_reg, active_next;

    logic [XW-1:0] width_x;
    logic [XW-1:0] col_x;
    logic [XW-1:0] skip_sum;
    logic [XW-1:0] skip_col;
    logic [XW-1:0] pix_sum;
    logic [XW-1:0] pix_col;
    logic [7:0]    run_dec;
    logic          in_width;

    // Effective width, limited to the maximum
    assign width_x = (XW'(sprite_width) > MAX_W_X) ? MAX_W_X : XW'(sprite_width);
    assign col_x   = XW'(column_reg);

    // Saturating column advances
    assign skip_sum = col_x + XW'(stream_byte);
    assign skip_col = (skip_sum > MAX_W_X) ? MAX_W_X : skip_sum;
    assign pix_sum  = col_x + XW'(1);
    assign pix_col  = (pix_sum > MAX_W_X) ? MAX_W_X : pix_sum;
    assign run_dec  = run_reg - 8'd1;
    assign in_width = col_x < width_x;

    // Next state and requests
    always_comb begin
        phase_next  = phase_reg;
        column_next = column_reg;
        run_next    = run_reg;
        row_next    = row_reg;
        active_next = active_reg;

        pal_wr.we    = 1'b0;
        pal_wr.index = palette_index;
        pal_wr.color = (palette_format == FMT_RGB888) ? rgb888_to_565(palette_color)
                                                      : palette_color[RGB565_W-1:0];

        pix_req.emit  = 1'b0;
        pix_req.hit   = 32'(stream_byte) < PALETTE_ENTRIES;
        pix_req.x     = TEXEL_X_W'(column_reg);
        pix_req.y     = row_reg;
        pix_req.index = stream_byte;

        if (accept) begin
            priority if (kind == KIND_PALETTE) begin
                pal_wr.we = 32'(palette_index) < PALETTE_ENTRIES;
            end else if (kind == KIND_ROW) begin
                row_next    = row_number;
                column_next = '0;
                run_next    = '0;
                phase_next  = PH_SKIP;
                active_next = width_x != '0;
            end else if (kind == KIND_STREAM && active_reg) begin
                unique case (phase_reg)
                    PH_SKIP: begin
                        if (stream_byte == END_OF_ROW) begin
                            active_next = 1'b0;
                        end else begin
                            column_next = CW'(skip_col);
                            if (skip_col >= width_x) begin
                                active_next = 1'b0;
                            end else begin
                                phase_next = PH_COUNT;
                            end
                        end
                    end
                    PH_COUNT: begin
                        run_next   = stream_byte;
                        phase_next = (stream_byte == '0) ? PH_SKIP : PH_PIXELS;
                    end
                    PH_PIXELS: begin
                        pix_req.emit = in_width;
                        column_next  = CW'(pix_col);
                        run_next     = run_dec;
                        if (run_dec == '0) begin
                            if (pix_col >= width_x) begin
                                active_next = 1'b0;
                            end
                            phase_next = PH_SKIP;
                        end
                    end
                    default: begin
                        phase_next = PH_SKIP;
                    end
                endcase
            end else begin
                // unused kind, or a coded byte with no open row: dropped
            end
        end
    end

    // Decode state registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg  <= PH_SKIP;
            column_reg <= '0;
            run_reg    <= '0;
            row_reg    <= '0;
            active_reg <= 1'b0;
        end else begin
            phase_reg  <= phase_next;
            column_reg <= column_next;
            run_reg    <= run_next;
            row_reg    <= row_next;
            active_reg <= active_next;
        end
    end

endmodule

// ===== rtl/core/rle_sprite_row_decoder.sv =====
// Top level of the RLE sprite row decoder: config registers, parser, palette
// memory and the output pipeline. Depends on rsrd_pkg, rsrd_parser, rsrd_palette_ram.
//
// Usage:
//   Input stream (s_*): one item per transfer. s_tuser carries the kind
//   (palette write, row start, coded byte); s_tdata carries the fields.
//   Palette writes fill the palette memory, a row start opens a row, coded
//   bytes alternate skip count, visible count and palette indexes.
//   Output stream (m_*): one transfer per visible pixel inside the width,
//   carrying column, row and the opaque ARGB4444 texel.
//   Configuration: cfg_we writes sprite_width (index 0) or palette_format
//   (index 1) at the clock edge; write only while the block is idle.
//   Throughput: one item per cycle while s_tready is high. A pixel byte
//   accepted on the input passes the pixel stage (palette read with the
//   coordinates), then the output register, before it raises m_tvalid.
//   The palette read port serves one lookup per cycle.
//   Reset (aresetn low, synchronous) closes any row and empties the
//   pipeline; the palette keeps its contents and is undefined until written.
//   A stalled receiver holds the output register; the pixel stage behind it
//   still takes items until it holds a pixel, then s_tready drops.
module rle_sprite_row_decoder #(
    parameter int MAX_WIDTH       = rsrd_pkg::MAX_WIDTH_DEF,
    parameter int PALETTE_ENTRIES = rsrd_pkg::PALETTE_ENTRIES_DEF
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    // input stream
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // [7:0] palette_index, [31:8] palette_color, [41:32] row_number,
    // [49:42] stream_byte, [55:50] zero
    input  logic [rsrd_pkg::IN_TDATA_W-1:0]  s_tdata,
    // [1:0] kind
    input  logic [rsrd_pkg::KIND_W-1:0]      s_tuser,
    // output stream
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // [9:0] texel_x, [19:10] texel_y, [35:20] texel_argb, [39:36] zero
    output logic [rsrd_pkg::OUT_TDATA_W-1:0] m_tdata,
    // configuration
    input  logic                             cfg_we,
    input  logic [rsrd_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [rsrd_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
    import rsrd_pkg::*;

    localparam int AW = (PALETTE_ENTRIES > 1) ? $clog2(PALETTE_ENTRIES) : 1;

    logic [SPR_WIDTH_W-1:0] sprite_width_reg;
    logic                   palette_format_reg;

    logic     accept;
    logic     p1_advance;
    pal_wr_t  pal_wr;
    pix_req_t pix_req;

    logic [RGB565_W-1:0] rd_data;

    logic                 p1_valid_reg;
    logic                 p1_hit_reg;
    logic [TEXEL_X_W-1:0] p1_x_reg;
    logic [TEXEL_Y_W-1:0] p1_y_reg;

    logic                   out_valid_reg;
    logic [OUT_TDATA_W-1:0] out_data_reg;
    logic [ARGB_W-1:0]      p1_argb;

    // Handshake: the pixel stage frees up when the output register is empty or moves
    assign p1_advance = !out_valid_reg || m_tready;
    assign s_tready   = !p1_valid_reg || p1_advance;
    assign accept     = s_tvalid && s_tready;

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sprite_width_reg   <= SPR_WIDTH_W'(1);
            palette_format_reg <= FMT_RGB565;
        end else if (cfg_we) begin
            unique case (cfg_index)
                REG_SPRITE_WIDTH:   sprite_width_reg   <= cfg_wdata;
                REG_PALETTE_FORMAT: palette_format_reg <= cfg_wdata[0];
                default: ;
            endcase
        end
    end

    rsrd_parser #(
        .MAX_WIDTH       (MAX_WIDTH),
        .PALETTE_ENTRIES (PALETTE_ENTRIES)
    ) u_parser (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .accept         (accept),
        .kind           (s_tuser),
        .palette_index  (s_tdata[7:0]),
        .palette_color  (s_tdata[31:8]),
        .row_number     (s_tdata[41:32]),
        .stream_byte    (s_tdata[49:42]),
        .sprite_width   (sprite_width_reg),
        .palette_format (palette_format_reg),
        .pal_wr         (pal_wr),
        .pix_req        (pix_req)
    );

    rsrd_palette_ram #(
        .ENTRIES (PALETTE_ENTRIES),
        .AW      (AW)
    ) u_palette (
        .aclk    (aclk),
        .wr_en   (pal_wr.we),
        .wr_addr (pal_wr.index[AW-1:0]),
        .wr_data (pal_wr.color),
        .rd_en   (pix_req.emit),
        .rd_addr (pix_req.index[AW-1:0]),
        .rd_data (rd_data)
    );

    // Pixel stage: coordinates travel alongside the palette read
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p1_valid_reg <= 1'b0;
        end else if (s_tready) begin
            p1_valid_reg <= pix_req.emit;
        end
    end

    always_ff @(posedge aclk) begin
        if (pix_req.emit) begin
            p1_hit_reg <= pix_req.hit;
            p1_x_reg   <= pix_req.x;
            p1_y_reg   <= pix_req.y;
        end
    end

    // Index past the palette reads as color zero
    assign p1_argb = rgb565_to_argb(p1_hit_reg ? rd_data : '0);

    // Output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (p1_advance) begin
            out_valid_reg <= p1_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (p1_advance && p1_valid_reg) begin
            out_data_reg <= OUT_TDATA_W'({p1_argb, p1_y_reg, p1_x_reg});
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule

// ===== rtl/core/rsrd_checker.sv =====
// Port-level checker for the RLE sprite row decoder, bound to the top level.
// Depends on rsrd_pkg and rle_sprite_row_decoder_assert.svh.
`include "rle_sprite_row_decoder_assert.svh"

module rsrd_checker (
    input logic                             aclk,
    input logic                             aresetn,
    input logic                             s_tvalid,
    input logic                             s_tready,
    input logic                             m_tvalid,
    input logic                             m_tready,
    input logic [rsrd_pkg::OUT_TDATA_W-1:0] m_tdata
);
    import rsrd_pkg::*;

    // Reset empties the output
    `RSRD_ASSERT_ALWAYS(a_reset_clears, aclk, !aresetn |=> !m_tvalid)

    // A stalled result stays offered
    `RSRD_ASSERT(a_hold_stall, aclk, aresetn, m_tvalid && !m_tready |=> m_tvalid)

    // Every texel is opaque
    `RSRD_ASSERT(a_opaque, aclk, aresetn, m_tvalid |-> m_tdata[35:32] == ALPHA_OPAQUE)

    // A new result follows an earlier input transfer
    `RSRD_ASSERT(a_result_source, aclk, aresetn, $rose(m_tvalid) |-> $past(s_tvalid && s_tready, 2))

endmodule

bind rle_sprite_row_decoder rsrd_checker u_rsrd_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
